@@ hdl/btrc_pkg.sv @@
// ============================================================================
// btrc_pkg: shared types and helpers for the branch trace record converter
// Holds the trace and record word layouts, register name codes, instruction
// class codes and the slot placement functions.
// ============================================================================
package btrc_pkg;

    // Input word sizing
    localparam int NAME_W      = 7;
    localparam int SLOT_W      = 8;
    localparam int SRC_NAMES   = 6;
    localparam int DST_NAMES   = 3;
    localparam int SRC_CNT_W   = 3;
    localparam int DST_CNT_W   = 2;

    // Limits on how many names of each list are looked at
    localparam int MAX_SRC_IN  = 6;
    localparam int MAX_DST_IN  = 3;
    localparam int SRC_CNT_MAX = (1 << SRC_CNT_W) - 1;
    localparam int DST_CNT_MAX = (1 << DST_CNT_W) - 1;
    localparam int SRC_POS     = (MAX_SRC_IN < SRC_CNT_MAX) ? MAX_SRC_IN : SRC_CNT_MAX;
    localparam int DST_POS     = (MAX_DST_IN < DST_CNT_MAX) ? MAX_DST_IN : DST_CNT_MAX;

    // Output slot counts
    localparam int SRC_SLOTS   = 4;
    localparam int DST_SLOTS   = 2;

    // Register names in the output layout
    localparam logic [SLOT_W-1:0] NAME_NONE  = 8'd0;
    localparam logic [SLOT_W-1:0] NAME_SP    = 8'd6;
    localparam logic [SLOT_W-1:0] NAME_FLAGS = 8'd25;
    localparam logic [SLOT_W-1:0] NAME_IP    = 8'd26;
    localparam logic [SLOT_W-1:0] NAME_PLAIN = 8'd64;
    localparam logic [SLOT_W-1:0] NAME_SIMD  = 8'd128;

    // Register names in the input layout
    localparam logic [NAME_W-1:0] IN_SP      = 7'd31;
    localparam logic [NAME_W-1:0] IN_SIMD_HI = 7'd63;
    localparam logic [NAME_W-1:0] IN_FLAGS   = 7'd64;

    // Instruction class codes
    localparam logic [3:0] KIND_ALU      = 4'd0;
    localparam logic [3:0] KIND_LOAD     = 4'd1;
    localparam logic [3:0] KIND_STORE    = 4'd2;
    localparam logic [3:0] KIND_COND     = 4'd3;
    localparam logic [3:0] KIND_JUMP     = 4'd4;
    localparam logic [3:0] KIND_IND_JUMP = 4'd5;
    localparam logic [3:0] KIND_CALL     = 4'd9;
    localparam logic [3:0] KIND_IND_CALL = 4'd10;
    localparam logic [3:0] KIND_RETURN   = 4'd11;

    typedef struct packed {
        logic [63:0]                   pc;
        logic                          branch_flag;
        logic                          was_taken;
        logic [3:0]                    inst_kind;
        logic                          has_access;
        logic [63:0]                   access_addr;
        logic [SRC_CNT_W-1:0]          src_count;
        logic [SRC_NAMES*NAME_W-1:0]   src_names;
        logic [DST_CNT_W-1:0]          dst_count;
        logic [DST_NAMES*NAME_W-1:0]   dst_names;
    } trace_t;

    typedef struct packed {
        logic [63:0]                   out_ip;
        logic                          out_branch_flag;
        logic                          out_taken;
        logic [SRC_SLOTS*SLOT_W-1:0]   src_slots;
        logic [DST_SLOTS*SLOT_W-1:0]   dst_slots;
        logic [63:0]                   src_mem;
        logic [63:0]                   dst_mem;
    } record_t;

    typedef logic [SRC_SLOTS-1:0][SLOT_W-1:0] src_slots_t;
    typedef logic [DST_SLOTS-1:0][SLOT_W-1:0] dst_slots_t;

    typedef struct packed {
        src_slots_t slots;
        logic       placed;
    } src_place_t;

    // Translate one input register name; unknown names give NAME_NONE
    function automatic logic [SLOT_W-1:0] remap_name(input logic [NAME_W-1:0] r);
        logic [SLOT_W-1:0] m;
        if (r < IN_SP)
            m = NAME_PLAIN + {1'b0, r};
        else if (r == IN_SP)
            m = NAME_SP;
        else if (r <= IN_SIMD_HI)
            m = NAME_SIMD + {1'b0, r - (IN_SP + 7'd1)};
        else if (r == IN_FLAGS)
            m = NAME_FLAGS;
        else
            m = NAME_NONE;
        return m;
    endfunction

    // Put a name in the first free source slot unless it is already there
    function automatic src_place_t place_src(input src_slots_t slots,
                                             input logic [SLOT_W-1:0] r);
        src_place_t res;
        logic       done;
        res.slots  = slots;
        res.placed = (r == NAME_NONE);
        done       = (r == NAME_NONE);
        for (int i = 0; i < SRC_SLOTS; i++)
        begin
            if (!done)
            begin
                if (slots[i] == r)
                begin
                    done       = 1'b1;
                    res.placed = 1'b1;
                end
                else if (slots[i] == NAME_NONE)
                begin
                    res.slots[i] = r;
                    done         = 1'b1;
                    res.placed   = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Same for the destination slots; the caller never needs the outcome
    function automatic dst_slots_t place_dst(input dst_slots_t slots,
                                             input logic [SLOT_W-1:0] r);
        dst_slots_t res;
        logic       done;
        res  = slots;
        done = (r == NAME_NONE);
        for (int i = 0; i < DST_SLOTS; i++)
        begin
            if (!done)
            begin
                if (slots[i] == r)
                begin
                    done = 1'b1;
                end
                else if (slots[i] == NAME_NONE)
                begin
                    res[i] = r;
                    done   = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/btrc_if.sv @@
// ============================================================================
// btrc_if: stream channels of the branch trace record converter
// A valid/ready channel for incoming trace words and one for outgoing records.
// ============================================================================
interface btrc_trace_if;
    logic              valid;
    logic              ready;
    btrc_pkg::trace_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface btrc_record_if;
    logic              valid;
    logic              ready;
    btrc_pkg::record_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/btrc_convert.sv @@
// ============================================================================
// btrc_convert: remap and pack one trace word
// Translates register names, fills source and destination slots per class
// and routes the memory address of non-branch words.
// ============================================================================
module btrc_convert (
    input  btrc_pkg::trace_t  trace_word,
    output btrc_pkg::record_t record_word
);
    import btrc_pkg::*;

    logic [SRC_POS-1:0][NAME_W-1:0] src_raw;
    logic [SRC_POS-1:0][SLOT_W-1:0] src_map;
    logic [SRC_POS-1:0]             src_use;
    logic [DST_POS-1:0][SLOT_W-1:0] dst_map;
    logic [DST_POS-1:0]             dst_use;

    // Translate names; a position past the packed list reads as raw name zero
    always_comb
    begin
        for (int i = 0; i < SRC_POS; i++)
        begin
            if (i < SRC_NAMES)
                src_raw[i] = trace_word.src_names[(i % SRC_NAMES)*NAME_W +: NAME_W];
            else
                src_raw[i] = '0;
            src_map[i] = remap_name(src_raw[i]);
            src_use[i] = SRC_CNT_W'(i) < trace_word.src_count;
        end
        for (int i = 0; i < DST_POS; i++)
        begin
            dst_map[i] = remap_name(trace_word.dst_names[i*NAME_W +: NAME_W]);
            dst_use[i] = DST_CNT_W'(i) < trace_word.dst_count;
        end
    end

    src_slots_t        src;
    dst_slots_t        dst;
    src_place_t        pr;
    logic              any;
    logic [63:0]       src_mem;
    logic [63:0]       dst_mem;

    // Fill slots in order, one placement after another
    always_comb
    begin
        src     = '0;
        dst     = '0;
        pr      = '0;
        any     = 1'b0;
        src_mem = '0;
        dst_mem = '0;
        if (!trace_word.branch_flag)
        begin
            for (int i = 0; i < SRC_POS; i++)
            begin
                if (src_use[i])
                begin
                    pr  = place_src(src, src_map[i]);
                    src = pr.slots;
                end
            end
            for (int i = 0; i < DST_POS; i++)
            begin
                if (dst_use[i])
                    dst = place_dst(dst, dst_map[i]);
            end
            if (trace_word.has_access)
            begin
                if (trace_word.inst_kind == KIND_LOAD)
                    src_mem = trace_word.access_addr;
                else
                    dst_mem = trace_word.access_addr;
            end
        end
        else
        begin
            unique case (trace_word.inst_kind)
                KIND_COND:
                begin
                    pr  = place_src(src, NAME_IP);
                    src = pr.slots;
                    for (int i = 0; i < SRC_POS; i++)
                    begin
                        if (src_use[i] && src_map[i] != NAME_SP && src_map[i] != NAME_IP
                            && src_map[i] != NAME_NONE)
                        begin
                            pr  = place_src(src, src_map[i]);
                            src = pr.slots;
                            any = any | pr.placed;
                        end
                    end
                    if (!any)
                    begin
                        pr  = place_src(src, NAME_FLAGS);
                        src = pr.slots;
                    end
                    dst = place_dst(dst, NAME_IP);
                end
                KIND_JUMP:
                begin
                    dst = place_dst(dst, NAME_IP);
                end
                KIND_IND_JUMP:
                begin
                    for (int i = 0; i < SRC_POS; i++)
                    begin
                        if (src_use[i] && src_map[i] != NAME_SP && src_map[i] != NAME_IP
                            && src_map[i] != NAME_FLAGS && src_map[i] != NAME_NONE)
                        begin
                            pr  = place_src(src, src_map[i]);
                            src = pr.slots;
                            any = any | pr.placed;
                        end
                    end
                    if (!any)
                    begin
                        pr  = place_src(src, NAME_PLAIN);
                        src = pr.slots;
                    end
                    dst = place_dst(dst, NAME_IP);
                end
                KIND_CALL:
                begin
                    pr  = place_src(src, NAME_SP);
                    pr  = place_src(pr.slots, NAME_IP);
                    src = pr.slots;
                    dst = place_dst(dst, NAME_SP);
                    dst = place_dst(dst, NAME_IP);
                end
                KIND_IND_CALL:
                begin
                    pr  = place_src(src, NAME_SP);
                    pr  = place_src(pr.slots, NAME_IP);
                    src = pr.slots;
                    // Stop at the first target register that lands in a slot
                    for (int i = 0; i < SRC_POS; i++)
                    begin
                        if (!any && src_use[i] && src_map[i] != NAME_SP
                            && src_map[i] != NAME_IP && src_map[i] != NAME_FLAGS
                            && src_map[i] != NAME_NONE)
                        begin
                            pr  = place_src(src, src_map[i]);
                            src = pr.slots;
                            any = pr.placed;
                        end
                    end
                    if (!any)
                    begin
                        pr  = place_src(src, NAME_PLAIN);
                        src = pr.slots;
                    end
                    dst = place_dst(dst, NAME_SP);
                    dst = place_dst(dst, NAME_IP);
                end
                KIND_RETURN:
                begin
                    pr  = place_src(src, NAME_SP);
                    src = pr.slots;
                    dst = place_dst(dst, NAME_SP);
                    dst = place_dst(dst, NAME_IP);
                end
                default:
                begin
                    // Leave every slot empty for other classes
                    src = '0;
                end
            endcase
        end
    end

    // Assemble the record word
    always_comb
    begin
        record_word.out_ip          = trace_word.pc;
        record_word.out_branch_flag = trace_word.branch_flag;
        record_word.out_taken       = trace_word.was_taken;
        record_word.src_slots       = src;
        record_word.dst_slots       = dst;
        record_word.src_mem         = src_mem;
        record_word.dst_mem         = dst_mem;
    end

endmodule

@@ hdl/branch_trace_record_converter.sv @@
// ============================================================================
// branch_trace_record_converter: trace record layout converter
// Takes decoded instruction trace words and returns records in the target
// simulator's layout, one record per word.
// ============================================================================
// Usage:
//   trace  - sink channel; one decoded instruction word per valid/ready beat.
//   record - source channel; one converted record word per accepted word.
//   A word is taken into an input register, converted by one pass of
//   combinational logic and caught in an output register. The record shows
//   on the record channel once the output register has taken it, which a
//   receiver stall can delay.
//   Throughput is one word per cycle while record.ready holds; the pass has
//   no state carried between words; input and output registers hold one word each.
//   When the receiver stalls, the output register holds its word and the
//   input register still takes one more word; after that trace.ready drops
//   until the record channel drains. ready is driven combinationally from
//   record.ready through both stages.
//   Reset clears both valid flags; no record is presented after reset until
//   a word has been accepted. Words are never dropped or repeated.
// ============================================================================
module branch_trace_record_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    btrc_trace_if.sink           trace,
    btrc_record_if.source        record
);
    import btrc_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    trace_t  in_data_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    record_t out_data_reg;
    record_t conv_word;
    logic    out_free;
    logic    in_free;

    // Stage handshakes: a stage takes a word when it is empty or draining
    assign out_free    = !out_valid_reg || record.ready;
    assign in_free     = !in_valid_reg || out_free;
    assign trace.ready = in_free;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_free)
            in_valid_next = trace.valid;
        if (out_free)
            out_valid_next = in_valid_reg;
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold input word
    always_ff @(posedge clk)
    begin
        if (in_free && trace.valid)
            in_data_reg <= trace.data;
    end

    btrc_convert u_convert (
        .trace_word  (in_data_reg),
        .record_word (conv_word)
    );

    // Hold converted record
    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
            out_data_reg <= conv_word;
    end

    assign record.valid = out_valid_reg;
    assign record.data  = out_data_reg;

endmodule

@@ test/tb_branch_trace_record_converter.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_branch_trace_record_converter: stream test of the trace record converter
// Drives decoded trace words through the valid/ready input channel with
// random idle gaps and receiver stalls. Each accepted word is converted by a
// local predictor, and each record that comes out is checked field by field
// against the oldest pending prediction. Runs directed corner words first,
// then random streams under three idle patterns.
// ============================================================================
module tb_branch_trace_record_converter;

    import btrc_pkg::*;

    logic clk;
    logic rst_n;

    btrc_trace_if  trace_ch ();
    btrc_record_if record_ch ();

    branch_trace_record_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .trace  (trace_ch),
        .record (record_ch)
    );

    // Idle odds in percent for each side of the stream
    int src_idle_pct;
    int snk_idle_pct;

    record_t pending_records[$];
    int      fault_count;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Map one input register name to its output name; unknown names give none
    function automatic logic [SLOT_W-1:0] target_name(input logic [NAME_W-1:0] r);
        if (r < 7'd31)
            return NAME_PLAIN + 8'(r);
        if (r == 7'd31)
            return NAME_SP;
        if (r < 7'd64)
            return NAME_SIMD + 8'(r - 7'd32);
        if (r == 7'd64)
            return NAME_FLAGS;
        return NAME_NONE;
    endfunction

    // Add a name to the first free slot unless present; false when it found no room
    function automatic bit add_name(inout logic [3:0][SLOT_W-1:0] slots,
                                    input int n, input logic [SLOT_W-1:0] r);
        if (r == NAME_NONE)
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (slots[i] == r)
                return 1'b1;
            if (slots[i] == NAME_NONE)
            begin
                slots[i] = r;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic record_t convert_trace(input trace_t t);
        logic [3:0][SLOT_W-1:0] src;
        logic [3:0][SLOT_W-1:0] dst;
        logic [SLOT_W-1:0]      m;
        record_t                r;
        int                     scnt;
        int                     dcnt;
        bit                     any;
        src  = '0;
        dst  = '0;
        r    = '0;
        any  = 1'b0;
        scnt = (t.src_count > MAX_SRC_IN) ? MAX_SRC_IN : int'(t.src_count);
        dcnt = (t.dst_count > MAX_DST_IN) ? MAX_DST_IN : int'(t.dst_count);

        if (!t.branch_flag)
        begin
            for (int i = 0; i < scnt; i++)
                void'(add_name(src, SRC_SLOTS, target_name(t.src_names[i*NAME_W +: NAME_W])));
            for (int i = 0; i < dcnt; i++)
                void'(add_name(dst, DST_SLOTS, target_name(t.dst_names[i*NAME_W +: NAME_W])));
            // Loads read memory; any other access writes it
            if (t.has_access)
            begin
                if (t.inst_kind == KIND_LOAD)
                    r.src_mem = t.access_addr;
                else
                    r.dst_mem = t.access_addr;
            end
        end
        else
        begin
            case (t.inst_kind)
                KIND_COND:
                begin
                    void'(add_name(src, SRC_SLOTS, NAME_IP));
                    for (int i = 0; i < scnt; i++)
                    begin
                        m = target_name(t.src_names[i*NAME_W +: NAME_W]);
                        if (m != NAME_SP && m != NAME_IP && m != NAME_NONE)
                            if (add_name(src, SRC_SLOTS, m))
                                any = 1'b1;
                    end
                    if (!any)
                        void'(add_name(src, SRC_SLOTS, NAME_FLAGS));
                    void'(add_name(dst, DST_SLOTS, NAME_IP));
                end
                KIND_JUMP:
                    void'(add_name(dst, DST_SLOTS, NAME_IP));
                KIND_IND_JUMP:
                begin
                    for (int i = 0; i < scnt; i++)
                    begin
                        m = target_name(t.src_names[i*NAME_W +: NAME_W]);
                        if (m != NAME_SP && m != NAME_IP && m != NAME_FLAGS && m != NAME_NONE)
                            if (add_name(src, SRC_SLOTS, m))
                                any = 1'b1;
                    end
                    if (!any)
                        void'(add_name(src, SRC_SLOTS, NAME_PLAIN));
                    void'(add_name(dst, DST_SLOTS, NAME_IP));
                end
                KIND_CALL:
                begin
                    void'(add_name(src, SRC_SLOTS, NAME_SP));
                    void'(add_name(src, SRC_SLOTS, NAME_IP));
                    void'(add_name(dst, DST_SLOTS, NAME_SP));
                    void'(add_name(dst, DST_SLOTS, NAME_IP));
                end
                KIND_IND_CALL:
                begin
                    void'(add_name(src, SRC_SLOTS, NAME_SP));
                    void'(add_name(src, SRC_SLOTS, NAME_IP));
                    // Only the first target register that lands counts
                    for (int i = 0; i < scnt; i++)
                    begin
                        m = target_name(t.src_names[i*NAME_W +: NAME_W]);
                        if (m != NAME_SP && m != NAME_IP && m != NAME_FLAGS && m != NAME_NONE)
                            if (add_name(src, SRC_SLOTS, m))
                            begin
                                any = 1'b1;
                                break;
                            end
                    end
                    if (!any)
                        void'(add_name(src, SRC_SLOTS, NAME_PLAIN));
                    void'(add_name(dst, DST_SLOTS, NAME_SP));
                    void'(add_name(dst, DST_SLOTS, NAME_IP));
                end
                KIND_RETURN:
                begin
                    void'(add_name(src, SRC_SLOTS, NAME_SP));
                    void'(add_name(dst, DST_SLOTS, NAME_SP));
                    void'(add_name(dst, DST_SLOTS, NAME_IP));
                end
                default:
                    ;
            endcase
        end

        r.out_ip          = t.pc;
        r.out_branch_flag = t.branch_flag;
        r.out_taken       = t.was_taken;
        r.src_slots       = src;
        r.dst_slots       = dst[1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------

    // Pack six input names, the first one lowest
    function automatic logic [SRC_NAMES*NAME_W-1:0] names6(input int a, b, c, d, e, f);
        return {7'(f), 7'(e), 7'(d), 7'(c), 7'(b), 7'(a)};
    endfunction

    function automatic logic [DST_NAMES*NAME_W-1:0] names3(input int a, b, c);
        return {7'(c), 7'(b), 7'(a)};
    endfunction

    function automatic trace_t make_word(input logic [63:0] pc, input bit br, input bit tk,
                                         input logic [3:0] kind, input bit acc,
                                         input logic [63:0] addr, input int scnt,
                                         input logic [SRC_NAMES*NAME_W-1:0] sn,
                                         input int dcnt,
                                         input logic [DST_NAMES*NAME_W-1:0] dn);
        trace_t w;
        w.pc          = pc;
        w.branch_flag = br;
        w.was_taken   = tk;
        w.inst_kind   = kind;
        w.has_access  = acc;
        w.access_addr = addr;
        w.src_count   = 3'(scnt);
        w.src_names   = sn;
        w.dst_count   = 2'(dcnt);
        w.dst_names   = dn;
        return w;
    endfunction

    // Mostly valid names, with repeats of a few hot ones and some unknowns
    function automatic logic [NAME_W-1:0] pick_name();
        case ($urandom_range(9))
            0:       return 7'($urandom_range(127));
            1:       return 7'd31;
            2:       return 7'd64;
            3:       return 7'($urandom_range(3));
            default: return 7'($urandom_range(65));
        endcase
    endfunction

    function automatic trace_t random_word();
        trace_t w;
        w.pc          = {$urandom, $urandom};
        w.was_taken   = 1'($urandom);
        w.has_access  = 1'($urandom);
        w.access_addr = {$urandom, $urandom};
        // Scramble every field now and then
        if ($urandom_range(99) < 12)
        begin
            w.branch_flag = 1'($urandom);
            w.inst_kind   = 4'($urandom);
            w.src_count   = 3'($urandom);
            w.src_names   = 42'({$urandom, $urandom});
            w.dst_count   = 2'($urandom);
            w.dst_names   = 21'($urandom);
            return w;
        end
        w.branch_flag = 1'($urandom);
        if (w.branch_flag)
        begin
            case ($urandom_range(6))
                0:       w.inst_kind = KIND_COND;
                1:       w.inst_kind = KIND_JUMP;
                2:       w.inst_kind = KIND_IND_JUMP;
                3:       w.inst_kind = KIND_CALL;
                4:       w.inst_kind = KIND_IND_CALL;
                5:       w.inst_kind = KIND_RETURN;
                default: w.inst_kind = 4'($urandom_range(15));
            endcase
        end
        else if ($urandom_range(3) != 0)
            w.inst_kind = 4'($urandom_range(KIND_STORE));
        else
            w.inst_kind = 4'($urandom_range(15));
        w.src_count = 3'($urandom_range(7));
        w.dst_count = 2'($urandom_range(3));
        for (int i = 0; i < SRC_NAMES; i++)
            w.src_names[i*NAME_W +: NAME_W] = pick_name();
        for (int i = 0; i < DST_NAMES; i++)
            w.dst_names[i*NAME_W +: NAME_W] = pick_name();
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one word, with random idle cycles ahead of it, and log its record
    task automatic send_word(input trace_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            trace_ch.valid <= 1'b0;
            @(posedge clk);
        end
        trace_ch.valid <= 1'b1;
        trace_ch.data  <= w;
        do
            @(posedge clk);
        while (!trace_ch.ready);
        pending_records.push_back(convert_trace(w));
    endtask

    // Hold off the sender until every pending record is out
    task automatic wait_records_drained();
        trace_ch.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_plain_records();
        // Name extremes: general, stack, SIMD ends; SIMD top and flags overflow
        send_word(make_word('1, 0, 0, KIND_ALU, 0, '0,
                            6, names6(0, 30, 31, 32, 63, 64), 3, names3(65, 0, 1)));
        // Load with count clamped, repeats and unknown names
        send_word(make_word('0, 0, 1, KIND_LOAD, 1, '1,
                            7, names6(1, 1, 127, 66, 2, 3), 0, names3(127, 127, 127)));
        // Store: address to the destination word, repeated destinations
        send_word(make_word(64'h8000_0000_0000_0001, 0, 0, KIND_STORE, 1,
                            64'hA5A5_5A5A_0F0F_F0F0, 0, '1, 3, names3(31, 31, 64)));
        // Non-load access of an ALU word and an unlisted class
        send_word(make_word(64'h1234, 0, 1, KIND_ALU, 1, 64'h0123_4567_89AB_CDEF,
                            2, names6(65, 64, 0, 0, 0, 0), 1, names3(63, 0, 0)));
        send_word(make_word(64'h5678, 0, 0, 4'd15, 1, 64'hFEDC_BA98_7654_3210,
                            5, names6(10, 20, 33, 44, 55, 0), 2, names3(5, 6, 7)));
        // Load without an access moves no address
        send_word(make_word(64'h9ABC, 0, 0, KIND_LOAD, 0, '1,
                            3, names6(65, 65, 65, 0, 0, 0), 2, names3(65, 65, 0)));
    endtask

    task automatic test_branch_signatures();
        // Conditional: no usable source falls back to flags
        send_word(make_word(64'h100, 1, 1, KIND_COND, 0, '0, 0, '0, 0, '0));
        send_word(make_word(64'h104, 1, 0, KIND_COND, 0, '0,
                            3, names6(31, 65, 100, 0, 0, 0), 2, names3(3, 4, 0)));
        // Conditional: flags source placed, overflow past four slots
        send_word(make_word(64'h108, 1, 1, KIND_COND, 0, '0,
                            6, names6(64, 0, 5, 40, 41, 42), 0, '0));
        // Branch with a memory access ignores the address
        send_word(make_word(64'h10C, 1, 1, KIND_COND, 1, '1,
                            1, names6(2, 0, 0, 0, 0, 0), 0, '0));
        send_word(make_word(64'h110, 1, 1, KIND_JUMP, 1, '1, 6, '1, 3, '1));
        // Indirect jump: nothing usable gives the plain register
        send_word(make_word(64'h114, 1, 1, KIND_IND_JUMP, 0, '0, 0, '0, 0, '0));
        send_word(make_word(64'h118, 1, 1, KIND_IND_JUMP, 0, '0,
                            3, names6(64, 31, 70, 0, 0, 0), 0, '0));
        send_word(make_word(64'h11C, 1, 0, KIND_IND_JUMP, 0, '0,
                            6, names6(3, 4, 5, 6, 7, 8), 1, names3(9, 0, 0)));
        send_word(make_word(64'h120, 1, 1, KIND_CALL, 0, '0,
                            2, names6(1, 2, 0, 0, 0, 0), 2, names3(1, 2, 0)));
        // Indirect call: first usable source only, else the plain register
        send_word(make_word(64'h124, 1, 1, KIND_IND_CALL, 0, '0,
                            4, names6(31, 64, 10, 11, 0, 0), 0, '0));
        send_word(make_word(64'h128, 1, 1, KIND_IND_CALL, 1, '1,
                            2, names6(64, 31, 0, 0, 0, 0), 0, '0));
        send_word(make_word(64'h12C, 1, 1, KIND_RETURN, 0, '0,
                            2, names6(30, 63, 0, 0, 0, 0), 1, names3(0, 0, 0)));
        // Branch of a class with no signature leaves every slot empty
        send_word(make_word(64'h130, 1, 1, KIND_ALU, 0, '0, 6, '0, 3, '0));
        send_word(make_word(64'h134, 1, 0, KIND_STORE, 1, '1,
                            6, names6(1, 2, 3, 4, 5, 6), 3, names3(1, 2, 3)));
        send_word(make_word(64'h138, 1, 1, 4'd6, 0, '0, 1, names6(7, 0, 0, 0, 0, 0), 0, '0));
        send_word(make_word(64'h13C, 1, 0, 4'd8, 0, '0, 0, '0, 0, '0));
        send_word(make_word(64'h140, 1, 1, 4'd15, 1, '1, 7, '1, 3, '1));
    endtask

    task automatic test_random_stream(input int n, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n; i++)
            send_word(random_word());
    endtask

    // ------------------------------------------------------------------------
    // Record checker and receiver stalls
    // ------------------------------------------------------------------------

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] seen);
        if (seen !== want)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("%t: %s mismatch: expected %h, got %h", $realtime, fname, want, seen);
        end
    endtask

    initial
    begin : record_monitor
        record_t seen;
        record_t want;
        record_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && record_ch.valid === 1'b1 && record_ch.ready)
            begin
                seen = record_ch.data;
                if (pending_records.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%t: record with no word pending: %h", $realtime, seen);
                end
                else
                begin
                    want = pending_records.pop_front();
                    check_field("out_ip", want.out_ip, seen.out_ip);
                    check_field("out_branch_flag", 64'(want.out_branch_flag),
                                64'(seen.out_branch_flag));
                    check_field("out_taken", 64'(want.out_taken), 64'(seen.out_taken));
                    check_field("src_slots", 64'(want.src_slots), 64'(seen.src_slots));
                    check_field("dst_slots", 64'(want.dst_slots), 64'(seen.dst_slots));
                    check_field("src_mem", want.src_mem, seen.src_mem);
                    check_field("dst_mem", want.dst_mem, seen.dst_mem);
                end
            end
            // Stall the receiver at random
            record_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Clock, reset and run order
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_branch_trace_record_converter: done, errors");
        $finish;
    end

    initial
    begin
        fault_count    = 0;
        src_idle_pct   = 21;
        snk_idle_pct   = 63;
        rst_n          <= 1'b0;
        trace_ch.valid <= 1'b0;
        trace_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_records();
        test_branch_signatures();
        wait_records_drained();
        test_random_stream(640, 21, 63);
        wait_records_drained();
        test_random_stream(640, 63, 21);
        wait_records_drained();
        test_random_stream(620, 0, 0);

        // Drain, then watch for stray records
        wait_records_drained();
        repeat (20) @(posedge clk);
        if (pending_records.size() != 0)
            fault_count++;

        if (fault_count == 0)
            $display("tb_branch_trace_record_converter: done, clean");
        else
            $display("tb_branch_trace_record_converter: done, errors");
        $finish;
    end

endmodule
